/* design/masked_byte_pattern_search_assert.svh */
// Assertion helpers for the byte pattern search block.
`ifndef MASKED_BYTE_PATTERN_SEARCH_ASSERT_SVH
`define MASKED_BYTE_PATTERN_SEARCH_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MBPS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define MBPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/mbps_pkg.sv */
`default_nettype none

package mbps_pkg;

    localparam int PATTERN_MAX_DEF = 16;
    localparam int OFFSET_BITS_DEF = 32;

    localparam int DATA_W       = 8;
    localparam int OFFSET_OUT_W = 32;
    localparam int LEN_W        = 5;
    localparam int REG_BYTES    = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 64;

    localparam logic [REG_BYTES-1:0] CARE_RESET = '1;
    localparam logic [LEN_W-1:0]     LEN_RESET  = 5'd16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LOW  = 2'd0,
        CFG_PATTERN_HIGH = 2'd1,
        CFG_CARE_MASK    = 2'd2,
        CFG_LENGTH       = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] pattern_low;
        logic [CFG_DATA_W-1:0] pattern_high;
        logic [REG_BYTES-1:0]  care_mask;
        logic [LEN_W-1:0]      pattern_length;
    } cfg_t;

    typedef struct packed {
        logic                    emit;
        logic                    found;
        logic [OFFSET_OUT_W-1:0] match_offset;
    } result_t;

endpackage

`default_nettype wire

/* design/masked_byte_pattern_search.sv */
// Masked byte pattern search: finds the first place in a byte region where
// a programmed pattern of up to 16 bytes occurs; care bits of 0 match any byte.
// Input stream: one byte per request in s_axis_tdata, s_axis_tlast marks the
// last byte of a region. Output stream: one request per region, m_axis_tuser
// is the found flag, m_axis_tdata the start offset from the region start
// (0 when not found). A match is reported on the byte that completes it; a
// region without a match reports on its last byte. The last byte clears the
// window, byte count and reported flag for the next region.
// Config: cfg_valid/cfg_index/cfg_data write one register per request
// (0 pattern low, 1 pattern high, 2 care mask, 3 length); cfg_ready is
// always high. Write config only while no byte is in flight.
// Timing: an input register and a result register bracket the window shift
// plus parallel masked compare; a byte moves from the input register through
// the compare into the result register, visible to the receiver from then on.
// Throughput: one byte per cycle outside stalls, bounded by the single compare stage.
// When the receiver stalls with a result pending, the input register holds
// its byte and s_axis_tready drops until the result is taken.
// Reset clears flags, window, count and pattern; care mask all ones, length 16.
`default_nettype none

module masked_byte_pattern_search #(
    parameter int PATTERN_MAX = mbps_pkg::PATTERN_MAX_DEF,
    parameter int OFFSET_BITS = mbps_pkg::OFFSET_BITS_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // Byte stream in
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    input  wire logic [mbps_pkg::DATA_W-1:0]           s_axis_tdata,  // [7:0] data_byte
    input  wire logic                                  s_axis_tlast,
    // Result stream out
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    output logic [mbps_pkg::OFFSET_OUT_W-1:0]          m_axis_tdata,  // [31:0] match_offset
    output logic                                       m_axis_tuser,  // [0] found
    // Register writes
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [mbps_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [mbps_pkg::CFG_DATA_W-1:0]       cfg_data
);

`include "masked_byte_pattern_search_assert.svh"

    mbps_pkg::cfg_t    cfg;
    mbps_pkg::result_t res;

    logic                             in_accept;
    logic                             fire;
    logic                             s1_valid_reg;
    logic                             s1_valid_next;
    logic [mbps_pkg::DATA_W-1:0]      s1_byte_reg;
    logic                             s1_last_reg;
    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic                             out_found_reg;
    logic [mbps_pkg::OFFSET_OUT_W-1:0] out_offset_reg;

    assign cfg_ready = 1'b1;

    mbps_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Advance the held byte whenever the result slot is free or being drained.
    assign fire          = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || fire;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    mbps_scan #(
        .PATTERN_MAX(PATTERN_MAX),
        .OFFSET_BITS(OFFSET_BITS)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (fire),
        .data_byte  (s1_byte_reg),
        .region_end (s1_last_reg),
        .cfg        (cfg),
        .res        (res)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
            s1_valid_next = 1'b1;
        else if (fire)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (fire && res.emit)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: input on a taken request, result on an emitted one, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_byte_reg <= s_axis_tdata;
            s1_last_reg <= s_axis_tlast;
        end
        if (fire && res.emit)
        begin
            out_found_reg  <= res.found;
            out_offset_reg <= res.match_offset;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_offset_reg;
    assign m_axis_tuser  = out_found_reg;

    // A not-found result never carries an offset.
    `MBPS_ASSERT_NOW(a_notfound_zero, clk, rst_n, out_valid_reg && !out_found_reg, out_offset_reg == '0, "not-found result with nonzero offset")
    // A byte stalled behind a pending result stays in the input register.
    `MBPS_ASSERT_NEXT(a_stall_holds, clk, rst_n, s1_valid_reg && out_valid_reg && !m_axis_tready, s1_valid_reg, "held byte lost during output stall")
    // Input backpressure only comes from a stalled result with a byte waiting.
    `MBPS_ASSERT_NOW(a_ready_cause, clk, rst_n, !s_axis_tready, s1_valid_reg && out_valid_reg && !m_axis_tready, "input stalled without cause")

endmodule

`default_nettype wire

/* design/mbps_cfg_regs.sv */
`default_nettype none

module mbps_cfg_regs (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                wr_en,
    input  wire logic [mbps_pkg::CFG_IDX_W-1:0]      wr_index,
    input  wire logic [mbps_pkg::CFG_DATA_W-1:0]     wr_data,
    output mbps_pkg::cfg_t                           cfg
);

    mbps_pkg::cfg_t cfg_reg;
    mbps_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (mbps_pkg::cfg_index_t'(wr_index))
                mbps_pkg::CFG_PATTERN_LOW:  cfg_next.pattern_low  = wr_data;
                mbps_pkg::CFG_PATTERN_HIGH: cfg_next.pattern_high = wr_data;
                mbps_pkg::CFG_CARE_MASK:
                    cfg_next.care_mask = wr_data[mbps_pkg::REG_BYTES-1:0];
                mbps_pkg::CFG_LENGTH:
                    cfg_next.pattern_length = wr_data[mbps_pkg::LEN_W-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pattern_low    <= '0;
            cfg_reg.pattern_high   <= '0;
            cfg_reg.care_mask      <= mbps_pkg::CARE_RESET;
            cfg_reg.pattern_length <= mbps_pkg::LEN_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* design/mbps_matcher.sv */
`default_nettype none

module mbps_matcher #(
    parameter int PATTERN_MAX = mbps_pkg::PATTERN_MAX_DEF
) (
    input  wire logic [PATTERN_MAX-1:0][mbps_pkg::DATA_W-1:0] window,
    input  wire logic [mbps_pkg::LEN_W-1:0]                   len,
    input  wire mbps_pkg::cfg_t                               cfg,
    output logic                                              hit
);

    // Only the first positions have a pattern byte; the rest match anything.
    localparam int NPOS      = (PATTERN_MAX < mbps_pkg::REG_BYTES) ?
                               PATTERN_MAX : mbps_pkg::REG_BYTES;
    localparam int WIN_IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int SEL_W     = (WIN_IDX_W > mbps_pkg::LEN_W) ?
                               WIN_IDX_W : mbps_pkg::LEN_W;

    logic [mbps_pkg::REG_BYTES-1:0][mbps_pkg::DATA_W-1:0] pattern;
    logic [NPOS-1:0]                                      pos_ok;
    logic [SEL_W-1:0]                                     sel;

    assign pattern = {cfg.pattern_high, cfg.pattern_low};

    // Pattern position i lines up with window entry len-1-i (entry 0 is newest).
    always_comb
    begin
        pos_ok = '1;
        sel    = '0;
        for (int i = 0; i < NPOS; i++)
        begin
            sel = SEL_W'(len) - SEL_W'(i) - SEL_W'(1);
            if ((SEL_W'(i) < SEL_W'(len)) && cfg.care_mask[i] &&
                (window[sel[WIN_IDX_W-1:0]] != pattern[i]))
            begin
                pos_ok[i] = 1'b0;
            end
        end
    end

    assign hit = &pos_ok;

endmodule

`default_nettype wire

/* design/mbps_scan.sv */
`default_nettype none

module mbps_scan #(
    parameter int PATTERN_MAX = mbps_pkg::PATTERN_MAX_DEF,
    parameter int OFFSET_BITS = mbps_pkg::OFFSET_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          advance,
    input  wire logic [mbps_pkg::DATA_W-1:0]   data_byte,
    input  wire logic                          region_end,
    input  wire mbps_pkg::cfg_t                cfg,
    output mbps_pkg::result_t                  res
);

    localparam int LEN_CAP = (PATTERN_MAX < 31) ? PATTERN_MAX : 31;

    logic [PATTERN_MAX-1:0][mbps_pkg::DATA_W-1:0] win_reg;
    logic [PATTERN_MAX-1:0][mbps_pkg::DATA_W-1:0] win_next;
    logic [PATTERN_MAX-1:0][mbps_pkg::DATA_W-1:0] shifted;
    logic [OFFSET_BITS-1:0]                       count_reg;
    logic [OFFSET_BITS-1:0]                       count_next;
    logic [OFFSET_BITS-1:0]                       count_inc;
    logic [OFFSET_BITS-1:0]                       offset_short;
    logic [OFFSET_BITS+mbps_pkg::OFFSET_OUT_W-1:0] offset_wide;
    logic                                         reported_reg;
    logic                                         reported_next;
    logic [mbps_pkg::LEN_W-1:0]                   len;
    logic                                         window_hit;
    logic                                         hit;

    // Clamp the programmed length into 1..min(PATTERN_MAX, 31).
    always_comb
    begin
        len = cfg.pattern_length;
        if (cfg.pattern_length == '0)
            len = mbps_pkg::LEN_W'(1);
        else if (int'(cfg.pattern_length) > LEN_CAP)
            len = mbps_pkg::LEN_W'(LEN_CAP);
    end

    always_comb
    begin
        shifted[0] = data_byte;
        for (int i = 1; i < PATTERN_MAX; i++)
            shifted[i] = win_reg[i-1];
    end

    // Saturating byte count.
    assign count_inc = (count_reg == '1) ? count_reg : count_reg + OFFSET_BITS'(1);

    mbps_matcher #(
        .PATTERN_MAX(PATTERN_MAX)
    ) u_matcher (
        .window (shifted),
        .len    (len),
        .cfg    (cfg),
        .hit    (window_hit)
    );

    assign hit          = !reported_reg && (count_inc >= OFFSET_BITS'(len)) && window_hit;
    assign offset_short = count_inc - OFFSET_BITS'(len);
    assign offset_wide  = {{mbps_pkg::OFFSET_OUT_W{1'b0}}, offset_short};

    always_comb
    begin
        res.emit         = hit || (region_end && !reported_reg);
        res.found        = hit;
        res.match_offset = hit ? offset_wide[mbps_pkg::OFFSET_OUT_W-1:0] : '0;
    end

    always_comb
    begin
        win_next      = win_reg;
        count_next    = count_reg;
        reported_next = reported_reg;
        if (advance)
        begin
            if (region_end)
            begin
                win_next      = '0;
                count_next    = '0;
                reported_next = 1'b0;
            end
            else
            begin
                win_next      = shifted;
                count_next    = count_inc;
                reported_next = reported_reg || hit;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg      <= '0;
            count_reg    <= '0;
            reported_reg <= 1'b0;
        end
        else
        begin
            win_reg      <= win_next;
            count_reg    <= count_next;
            reported_reg <= reported_next;
        end
    end

endmodule

`default_nettype wire
